// File: rtl/dtg_pkg.sv
// Package for the DTMF tone generator: widths, key frequencies, state codes,
// the key lookup and the sine table builder.
// Depends on nothing; used by dtg_div, the generator core, dtg_checker and tb_top.
package dtg_pkg;

  localparam int PHASE_BITS     = 16;
  localparam int TABLE_SHIFT    = 8;
  localparam int SINE_AMPLITUDE = 8191;

  localparam int ROM_DEPTH   = 1 << TABLE_SHIFT;
  localparam int ROM_W       = 16;
  localparam int QUARTER     = ROM_DEPTH / 4;
  localparam int RATE_W      = 18;
  localparam int DIGIT_W     = 8;
  localparam int SAMPLE_W    = 15;
  localparam int SUM_W       = ROM_W + 1;
  localparam int FREQ_W      = 11;
  localparam int DIVIDEND_W  = FREQ_W + PHASE_BITS;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
  localparam int TAYLOR_TERMS = 12;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(8000);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(16383);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(16384));

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  localparam logic [FREQ_W-1:0] ROW_697  = FREQ_W'(697);
  localparam logic [FREQ_W-1:0] ROW_770  = FREQ_W'(770);
  localparam logic [FREQ_W-1:0] ROW_852  = FREQ_W'(852);
  localparam logic [FREQ_W-1:0] ROW_941  = FREQ_W'(941);
  localparam logic [FREQ_W-1:0] COL_1209 = FREQ_W'(1209);
  localparam logic [FREQ_W-1:0] COL_1336 = FREQ_W'(1336);
  localparam logic [FREQ_W-1:0] COL_1477 = FREQ_W'(1477);
  localparam logic [FREQ_W-1:0] COL_1633 = FREQ_W'(1633);

  localparam logic TONE_LOW  = 1'b0;
  localparam logic TONE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SUM,
    ST_BAD,
    ST_LOAD_START,
    ST_LOAD_WAIT
  } dtg_state_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] phase;
  } tone_entry_t;

  typedef struct packed {
    logic              found;
    logic [FREQ_W-1:0] row;
    logic [FREQ_W-1:0] col;
  } key_t;

  typedef logic signed [ROM_W-1:0] rom_t [ROM_DEPTH];

  function automatic key_t key_lookup(input logic [DIGIT_W-1:0] code);
    key_t k;
    k = '{found: 1'b1, row: ROW_697, col: COL_1209};
    case (code)
      "0": begin k.row = ROW_941; k.col = COL_1336; end
      "1": begin k.row = ROW_697; k.col = COL_1209; end
      "2": begin k.row = ROW_697; k.col = COL_1336; end
      "3": begin k.row = ROW_697; k.col = COL_1477; end
      "4": begin k.row = ROW_770; k.col = COL_1209; end
      "5": begin k.row = ROW_770; k.col = COL_1336; end
      "6": begin k.row = ROW_770; k.col = COL_1477; end
      "7": begin k.row = ROW_852; k.col = COL_1209; end
      "8": begin k.row = ROW_852; k.col = COL_1336; end
      "9": begin k.row = ROW_852; k.col = COL_1477; end
      "*": begin k.row = ROW_941; k.col = COL_1209; end
      "#": begin k.row = ROW_941; k.col = COL_1477; end
      "A": begin k.row = ROW_697; k.col = COL_1633; end
      "B": begin k.row = ROW_770; k.col = COL_1633; end
      "C": begin k.row = ROW_852; k.col = COL_1633; end
      "D": begin k.row = ROW_941; k.col = COL_1633; end
      default: begin k.found = 1'b0; end
    endcase
    return k;
  endfunction

  // Each Taylor term divides the previous one by (2n+2)(2n+3).
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
    logic [63:0] q;
    case (n)
      0:       q = t / 64'd6;
      1:       q = t / 64'd20;
      2:       q = t / 64'd42;
      3:       q = t / 64'd72;
      4:       q = t / 64'd110;
      5:       q = t / 64'd156;
      6:       q = t / 64'd210;
      7:       q = t / 64'd272;
      8:       q = t / 64'd342;
      9:       q = t / 64'd420;
      10:      q = t / 64'd506;
      11:      q = t / 64'd600;
      default: q = '0;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({1'b0, x});
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = taylor_div((term * x2) >> 30, n);
      if ((n % 2) == 1) begin
        sum = sum + $signed({1'b0, term});
      end else begin
        sum = sum - $signed({1'b0, term});
      end
    end
    return (sum < 0) ? 64'd0 : sum[63:0];
  endfunction

  function automatic rom_t sine_table();
    rom_t        tbl;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      q = 64'(i >> (TABLE_SHIFT - 2));
      r = 64'(i & (QUARTER - 1));
      if (q[0]) begin
        r = 64'(QUARTER) - r;
      end
      x = (r * 64'd2 * PI_Q30) >> TABLE_SHIFT;
      v = sine_q30(x) * 64'(SINE_AMPLITUDE);
      if (q < 64'd2) begin
        tbl[i] = ROM_W'((v + HALF_Q30) >> 30);
      end else if (v <= HALF_Q30) begin
        tbl[i] = '0;
      end else begin
        tbl[i] = ROM_W'(64'd0 - ((v - HALF_Q30) >> 30));
      end
    end
    return tbl;
  endfunction

endpackage

// File: rtl/dtg_div.sv
// Bit-serial restoring divider for the phase step: (freq << 16) / sample rate,
// one quotient bit per cycle, low 16 quotient bits kept. Uses dtg_pkg.
module dtg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dtg_pkg::FREQ_W-1:0]     freq,
  input  logic [dtg_pkg::RATE_W-1:0]     divisor,
  output logic                           done,
  output logic [dtg_pkg::PHASE_BITS-1:0] quot
);
  import dtg_pkg::*;

  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVIDEND_W-1:0] num_r, num_nxt;
  logic [RATE_W-1:0]     rem_r, rem_nxt;
  logic [PHASE_BITS-1:0] quot_r, quot_nxt;
  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;
  logic                  fits;

  always_comb begin
    trial    = {rem_r, num_r[DIVIDEND_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = trial >= {1'b0, divisor};
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      num_nxt  = {freq, {PHASE_BITS{1'b0}}};
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      num_nxt  = {num_r[DIVIDEND_W-2:0], 1'b0};
      rem_nxt  = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quot_nxt = {quot_r[PHASE_BITS-2:0], fits};
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = (divisor == '0) ? '0 : quot_r;

endmodule

// File: rtl/dtmf_tone_generator_core.sv
// DTMF tone generator core: two phase accumulators held in a two-entry tone
// state RAM, a 256-entry sine ROM and a shared serial step divider.
// Depends on dtg_pkg and dtg_div.
//
// One request is in flight at a time. A sample request (cmd 1) gives the low and
// then the high tone entry a read-modify-write in the tone state RAM, reads the
// sine ROM at each new phase through its registered read and sums the two values.
// A load request (cmd 0) with a valid key runs the bit-serial divider twice, once
// per tone, and writes each new step into the tone state RAM; an unknown key
// answers with the bad-digit flag, without the divider. The result register
// frees the input side, so a new request is taken in the cycle a result leaves.
// sample_rate must be written only while no request is in flight.
module dtmf_tone_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [dtg_pkg::RATE_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [dtg_pkg::DIGIT_W-1:0]         in_digit,
  input  logic                                in_reset_phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dtg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_bad_digit
);
  import dtg_pkg::*;

  localparam rom_t SINE_ROM = sine_table();

  dtg_state_t state_r, state_nxt;

  logic [RATE_W-1:0]          sample_rate_r;
  logic                       tone_idx_r, tone_idx_nxt;
  logic [FREQ_W-1:0]          row_freq_r;
  logic [FREQ_W-1:0]          col_freq_r;
  logic                       clr_phase_r;
  logic signed [ROM_W-1:0]    low_val_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_bad_digit_r;

  tone_entry_t                tone_mem [2];
  logic [1:0]                 tone_vld_r;
  tone_entry_t                rd_data_r;
  logic signed [ROM_W-1:0]    rom_data_r;

  key_t                       key;
  logic                       accept;
  logic                       rd_addr;
  logic                       mem_we;
  tone_entry_t                mem_wdata;
  logic [TABLE_SHIFT-1:0]     rom_addr;
  logic [PHASE_BITS-1:0]      new_phase;
  logic                       div_start;
  logic                       div_done;
  logic [PHASE_BITS-1:0]      div_quot;
  logic                       low_val_load;
  logic                       res_load;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_bad;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_sat;

  assign key       = key_lookup(in_digit);
  assign accept    = in_valid && in_ready;
  assign new_phase = rd_data_r.phase + rd_data_r.step;
  assign sum       = {low_val_r[ROM_W-1], low_val_r} + {rom_data_r[ROM_W-1], rom_data_r};
  assign sum_sat   = (sum > SUM_MAX) ? SUM_MAX : ((sum < SUM_MIN) ? SUM_MIN : sum);

  dtg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .freq    ((tone_idx_r == TONE_HIGH) ? col_freq_r : row_freq_r),
    .divisor (sample_rate_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            state_nxt = ST_ACC;
          end else if (key.found) begin
            state_nxt = ST_LOAD_START;
          end else begin
            state_nxt = ST_BAD;
          end
        end
      end
      ST_ACC: begin
        if (tone_idx_r == TONE_HIGH) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:        state_nxt = ST_IDLE;
      ST_BAD:        state_nxt = ST_IDLE;
      ST_LOAD_START: state_nxt = ST_LOAD_WAIT;
      ST_LOAD_WAIT: begin
        if (div_done) begin
          state_nxt = (tone_idx_r == TONE_HIGH) ? ST_IDLE : ST_LOAD_START;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    rd_addr      = tone_idx_r;
    tone_idx_nxt = tone_idx_r;
    mem_we       = 1'b0;
    mem_wdata    = rd_data_r;
    rom_addr     = '0;
    div_start    = 1'b0;
    low_val_load = 1'b0;
    res_load     = 1'b0;
    res_sample   = '0;
    res_bad      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = !out_valid_r || out_ready;
        rd_addr      = TONE_LOW;
        tone_idx_nxt = TONE_LOW;
      end
      ST_ACC: begin
        mem_we          = 1'b1;
        mem_wdata.phase = new_phase;
        rom_addr        = new_phase[PHASE_BITS-1 -: TABLE_SHIFT];
        if (tone_idx_r == TONE_LOW) begin
          rd_addr      = TONE_HIGH;
          tone_idx_nxt = TONE_HIGH;
        end else begin
          low_val_load = 1'b1;
        end
      end
      ST_SUM: begin
        res_load   = 1'b1;
        res_sample = sum_sat[SAMPLE_W-1:0];
      end
      ST_BAD: begin
        res_load = 1'b1;
        res_bad  = 1'b1;
      end
      ST_LOAD_START: begin
        div_start = 1'b1;
      end
      ST_LOAD_WAIT: begin
        if (div_done) begin
          mem_we         = 1'b1;
          mem_wdata.step = div_quot;
          if (clr_phase_r) begin
            mem_wdata.phase = '0;
          end
          if (tone_idx_r == TONE_LOW) begin
            tone_idx_nxt = TONE_HIGH;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      default: begin
        tone_idx_nxt = TONE_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tone_idx_r    <= TONE_LOW;
      sample_rate_r <= RATE_RESET;
      tone_vld_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tone_idx_r <= tone_idx_nxt;
      if (cfg_wr_en) begin
        sample_rate_r <= cfg_wr_data;
      end
      if (mem_we) begin
        tone_vld_r[mem_we ? tone_idx_r : TONE_LOW] <= 1'b1;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tone state RAM: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tone_mem[tone_idx_r] <= mem_wdata;
    end
    rd_data_r <= tone_vld_r[rd_addr] ? tone_mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    rom_data_r <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_freq_r  <= key.row;
      col_freq_r  <= key.col;
      clr_phase_r <= in_reset_phase;
    end
    if (low_val_load) begin
      low_val_r <= rom_data_r;
    end
    if (res_load) begin
      out_sample_r    <= res_sample;
      out_bad_digit_r <= res_bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_bad_digit = out_bad_digit_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while another was in flight");

  a_bad_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res_bad |-> res_sample == '0 && !mem_we)
    else $error("unknown key produced a sample or touched tone state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_LOAD_WAIT)
    else $error("divider finished outside a load");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid_r || $past(out_ready))
    else $error("result overwrote one still waiting");

endmodule

// File: tb/tb_dtg_pkg.sv
`timescale 1ns / 1ps
// Request command codes shared by the DTMF generator testbench files.
// Depends on nothing; used by dtg_checker and tb_top.
package tb_dtg_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

// File: tb/dtg_checker.sv
`timescale 1ns / 1ps
// Scoreboard for dtmf_tone_generator_core: tracks the rate register, predicts every
// accepted request with its own tone model and compares each result in order.
// Depends on dtg_pkg for widths and on tb_dtg_pkg for the command codes.
module dtg_checker
  import dtg_pkg::*;
  import tb_dtg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [RATE_W-1:0]          cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [DIGIT_W-1:0]         in_digit,
  input  logic                       in_reset_phase,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       out_bad_digit,
  output int                         mismatch_count,
  output int                         results_owed
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       bad_digit;
  } tone_result_t;

  tone_result_t          expected_results [$];
  int                    sine_lut [ROM_DEPTH];
  logic [RATE_W-1:0]     rate_hz;
  logic [PHASE_BITS-1:0] lo_phase;
  logic [PHASE_BITS-1:0] hi_phase;
  logic [PHASE_BITS-1:0] lo_step;
  logic [PHASE_BITS-1:0] hi_step;

  function automatic longint unsigned taylor_sine(input longint unsigned x);
    longint unsigned x_sq;
    longint unsigned term;
    longint unsigned div_by;
    longint          acc;
    x_sq = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      div_by = longint'((2 * n + 2) * (2 * n + 3));
      term   = ((term * x_sq) >> 30) / div_by;
      if (n % 2 == 1) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  initial begin : build_lut
    longint unsigned quad;
    longint unsigned offs;
    longint unsigned ang;
    longint unsigned amp;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      quad = i >> (TABLE_SHIFT - 2);
      offs = i & (QUARTER - 1);
      if (quad[0]) begin
        offs = QUARTER - offs;
      end
      ang = (offs * 64'd2 * PI_Q30) >> TABLE_SHIFT;
      amp = taylor_sine(ang) * 64'(SINE_AMPLITUDE);
      if (quad < 2) begin
        sine_lut[i] = int'((amp + HALF_Q30) >> 30);
      end else if (amp <= HALF_Q30) begin
        sine_lut[i] = 0;
      end else begin
        sine_lut[i] = -int'((amp - HALF_Q30) >> 30);
      end
    end
  end

  function automatic void dtmf_pair(input logic [DIGIT_W-1:0] code, output logic hit,
                                    output int unsigned row_hz, output int unsigned col_hz);
    hit    = 1'b1;
    row_hz = 0;
    col_hz = 0;
    case (code)
      "1", "2", "3", "A": row_hz = 697;
      "4", "5", "6", "B": row_hz = 770;
      "7", "8", "9", "C": row_hz = 852;
      "*", "0", "#", "D": row_hz = 941;
      default:            hit = 1'b0;
    endcase
    case (code)
      "1", "4", "7", "*": col_hz = 1209;
      "2", "5", "8", "0": col_hz = 1336;
      "3", "6", "9", "#": col_hz = 1477;
      "A", "B", "C", "D": col_hz = 1633;
      default:            col_hz = 0;
    endcase
  endfunction

  function automatic logic [PHASE_BITS-1:0] tone_step(input int unsigned hz);
    logic [63:0] scaled;
    if (rate_hz == '0) begin
      return '0;
    end
    scaled = 64'(hz) << PHASE_BITS;
    return PHASE_BITS'(scaled / rate_hz);
  endfunction

  function automatic tone_result_t predict_tone(input logic cmd, input logic [DIGIT_W-1:0] code,
                                                input logic clr);
    tone_result_t res;
    logic         hit;
    int unsigned  row_hz;
    int unsigned  col_hz;
    int           mix;
    res = '0;
    if (cmd == CMD_LOAD) begin
      dtmf_pair(code, hit, row_hz, col_hz);
      if (hit) begin
        if (clr) begin
          lo_phase = '0;
          hi_phase = '0;
        end
        lo_step = tone_step(row_hz);
        hi_step = tone_step(col_hz);
      end
      res.bad_digit = ~hit;
    end else begin
      lo_phase = lo_phase + lo_step;
      hi_phase = hi_phase + hi_step;
      mix = sine_lut[lo_phase >> (PHASE_BITS - TABLE_SHIFT)]
          + sine_lut[hi_phase >> (PHASE_BITS - TABLE_SHIFT)];
      if (mix > 16383) begin
        mix = 16383;
      end
      if (mix < -16384) begin
        mix = -16384;
      end
      res.sample = SAMPLE_W'(mix);
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    tone_result_t got;
    tone_result_t want;
    int           errs;
    if (!rst_n) begin
      expected_results.delete();
      rate_hz = RATE_RESET;
      lo_phase = '0;
      hi_phase = '0;
      lo_step = '0;
      hi_step = '0;
      mismatch_count <= 0;
      results_owed <= 0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        got.sample    = out_sample;
        got.bad_digit = out_bad_digit;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, sample %0d bad_digit %0b", $time,
                   got.sample, got.bad_digit);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t: sample expected %0d actual %0d", $time, want.sample, got.sample);
            errs++;
          end
          if (got.bad_digit !== want.bad_digit) begin
            $display("%0t: bad_digit expected %0b actual %0b", $time, want.bad_digit,
                     got.bad_digit);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_tone(in_cmd, in_digit, in_reset_phase));
      end
      if (cfg_wr_en) begin
        rate_hz = cfg_wr_data;
      end
      mismatch_count <= mismatch_count + errs;
      results_owed <= expected_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for dtmf_tone_generator_core: drives directed and random requests
// and rate writes under varying idle and stall patterns, then reports the verdict.
// Depends on dtg_pkg, tb_dtg_pkg, dtg_checker and the core itself.
module tb_top;
  import dtg_pkg::*;
  import tb_dtg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 64;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [RATE_W-1:0]          cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_cmd = 1'b0;
  logic [DIGIT_W-1:0]         in_digit = '0;
  logic                       in_reset_phase = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_bad_digit;
  int                         mismatch_count;
  int                         results_owed;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         cycle_count = 0;

  logic [DIGIT_W-1:0] key_codes [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                         "8", "9", "*", "#", "A", "B", "C", "D"};
  logic [RATE_W-1:0]  phase_rates [6] = '{18'd4000, 18'd192000, 18'd0, 18'd3,
                                          18'd262143, 18'd11025};
  int                 phase_idle [6]  = '{82, 0, 32, 0, 32, 82};
  int                 phase_stall [6] = '{0, 82, 32, 0, 32, 0};

  dtmf_tone_generator_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_digit       (in_digit),
    .in_reset_phase (in_reset_phase),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_bad_digit  (out_bad_digit)
  );

  dtg_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_digit       (in_digit),
    .in_reset_phase (in_reset_phase),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_bad_digit  (out_bad_digit),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dtmf_tone_generator_core: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic cmd, input logic [DIGIT_W-1:0] code, input logic clr);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_digit       <= code;
    in_reset_phase <= clr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_sample();
    send_request(CMD_SAMPLE, DIGIT_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] hz);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly a key load followed by a burst of samples, with stray samples and
  // loads of arbitrary codes mixed in.
  task automatic play_random(input int count);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(CMD_LOAD, DIGIT_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 14) begin
        send_sample();
        sent++;
      end else begin
        send_request(CMD_LOAD, key_codes[$urandom_range(15)], 1'($urandom_range(1)));
        sent++;
        burst = $urandom_range(12, 1);
        repeat (burst) begin
          send_sample();
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample();
    send_request(CMD_LOAD, "1", 1'b1);
    repeat (3) send_sample();
    send_request(CMD_LOAD, "D", 1'b0);
    repeat (2) send_sample();
    send_request(CMD_LOAD, 8'h00, 1'b1);
    send_sample();
    send_request(CMD_LOAD, 8'hFF, 1'b0);
    send_sample();
    send_request(CMD_LOAD, "/", 1'b1);
    send_request(CMD_LOAD, ":", 1'b0);
    send_request(CMD_LOAD, "a", 1'b1);
    send_request(CMD_LOAD, "5", 1'b1);
    send_sample();
    send_request(CMD_LOAD, "#", 1'b0);
    send_sample();
    send_request(CMD_LOAD, "*", 1'b1);
    send_sample();
    send_request(CMD_LOAD, "0", 1'b0);
    send_sample();
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_rate(phase_rates[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      play_random(31);
      wait_idle();
      play_random(31);
      wait_idle();
    end

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("dtmf_tone_generator_core: match");
    end else begin
      $display("dtmf_tone_generator_core: mismatch");
    end
    $finish;
  end

endmodule
